### hw/rtl/lkvc_pkg.sv
package lkvc_pkg;

  // width of the capacity register
  localparam int unsigned CapW = 5;
  localparam logic [CapW-1:0] CapReset = 5'd16;

  // request kind carried in s_axis_tuser
  localparam logic OpGet = 1'b0;
  localparam logic OpSet = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT   = 3'd0,
    ST_MISS  = 3'd1,
    ST_FREE  = 3'd2,
    ST_EVICT = 3'd3,
    ST_DUP   = 3'd4
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request word
    logic scan;    // sweep entry memories
    logic commit;  // update state and load result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // last entry is being compared this cycle
    logic out_free;   // result register can take a new word
  } dp_sts_t;

endpackage

### hw/rtl/lkvc_ctrl.sv
module lkvc_ctrl import lkvc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the result register before touching state
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/lkvc_dp.sv
module lkvc_dp import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CapW-1:0]       cfg_wdata_i,
  input  logic                  in_opcode_i,
  input  logic [KEY_BITS-1:0]   in_key_i,
  input  logic [VALUE_BITS-1:0] in_value_i,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            out_status_o,
  output logic [VALUE_BITS-1:0] out_read_value_o,
  output logic [KEY_BITS-1:0]   out_evicted_key_o
);

  localparam int unsigned IW   = $clog2(ENTRIES);
  localparam int unsigned UW   = $clog2(ENTRIES + 1);
  localparam int unsigned CMPW = (UW > CapW) ? UW : CapW;

  // configuration
  logic [CapW-1:0] cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // request word
  logic                  op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_opcode_i;
      key_q <= in_key_i;
      val_q <= in_value_i;
    end
  end

  // per-entry control state
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IW-1:0]      rank_q [ENTRIES];
  logic [IW-1:0]      rank_d [ENTRIES];
  logic [UW-1:0]      used_q, used_d;

  // entry memories, one read or one write per cycle
  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];
  logic [KEY_BITS-1:0]   mem_key_q;
  logic [VALUE_BITS-1:0] mem_val_q;

  // sweep counter
  logic [UW-1:0] cnt_q;
  logic          rd_en;
  logic [IW-1:0] rd_idx;
  logic          cmp_vld_q;
  logic [IW-1:0] cmp_idx_q;

  assign rd_en  = cmd_i.scan && (cnt_q < UW'(ENTRIES));
  assign rd_idx = cnt_q[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= rd_en;
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (rd_en) begin
        cnt_q <= cnt_q + UW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      cmp_idx_q <= rd_idx;
    end
  end

  // compare stage, one entry per cycle
  logic          cmp_valid, cmp_match, cmp_lru, cmp_free;
  logic [IW-1:0] last_rank;

  assign last_rank = IW'(used_q - UW'(1));
  assign cmp_valid = cmp_vld_q && valid_q[cmp_idx_q];
  assign cmp_match = cmp_valid && (mem_key_q == key_q);
  assign cmp_lru   = cmp_valid && (rank_q[cmp_idx_q] == last_rank);
  assign cmp_free  = cmp_vld_q && !valid_q[cmp_idx_q];

  logic                  hit_q, free_fnd_q;
  logic [IW-1:0]         hit_idx_q, free_idx_q, vict_idx_q;
  logic [VALUE_BITS-1:0] hit_val_q;
  logic [KEY_BITS-1:0]   vict_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      free_fnd_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q      <= 1'b0;
      free_fnd_q <= 1'b0;
    end else begin
      if (cmp_match) begin
        hit_q <= 1'b1;
      end
      if (cmp_free) begin
        free_fnd_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_match) begin
      hit_idx_q <= cmp_idx_q;
      hit_val_q <= mem_val_q;
    end
    if (cmp_free && !free_fnd_q) begin
      free_idx_q <= cmp_idx_q;
    end
    if (cmp_lru) begin
      vict_idx_q <= cmp_idx_q;
      vict_key_q <= mem_key_q;
    end
  end

  // outcome
  logic [CMPW-1:0] eff_cap;
  logic            full;
  status_e         status;
  logic            upd, ins, unbounded, grow;
  logic [IW-1:0]   sel;
  logic [IW-1:0]   limit;

  always_comb begin
    // capacity clamped to one .. ENTRIES
    if (cap_q == '0) begin
      eff_cap = CMPW'(1);
    end else if (CMPW'(cap_q) > CMPW'(ENTRIES)) begin
      eff_cap = CMPW'(ENTRIES);
    end else begin
      eff_cap = CMPW'(cap_q);
    end
    full = CMPW'(used_q) >= eff_cap;
  end

  always_comb begin
    upd       = 1'b0;
    ins       = 1'b0;
    unbounded = 1'b0;
    grow      = 1'b0;
    sel       = hit_idx_q;
    priority if (op_q == OpGet) begin
      status = hit_q ? ST_HIT : ST_MISS;
      upd    = hit_q;
    end else if (hit_q) begin
      status = ST_DUP;
    end else if (!full) begin
      status    = ST_FREE;
      sel       = free_idx_q;
      upd       = 1'b1;
      ins       = 1'b1;
      unbounded = 1'b1;
      grow      = 1'b1;
    end else begin
      status = ST_EVICT;
      sel    = vict_idx_q;
      upd    = 1'b1;
      ins    = 1'b1;
    end
  end

  assign limit = rank_q[sel];

  // recency lanes
  always_comb begin
    valid_d = valid_q;
    used_d  = used_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (cmd_i.commit && upd) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IW'(i) == sel) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (unbounded || (rank_q[i] < limit))) begin
          rank_d[i] = rank_q[i] + IW'(1);
        end
      end
      if (ins) begin
        valid_d[sel] = 1'b1;
      end
      if (grow) begin
        used_d = used_q + UW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      used_q  <= used_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && ins) begin
      key_mem[sel] <= key_q;
      val_mem[sel] <= val_q;
    end else if (rd_en) begin
      mem_key_q <= key_mem[rd_idx];
      mem_val_q <= val_mem[rd_idx];
    end
  end

  // result register
  logic                  out_valid_q;
  logic [2:0]            out_status_q;
  logic [VALUE_BITS-1:0] out_rd_q;
  logic [KEY_BITS-1:0]   out_ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= status;
      out_rd_q     <= (status == ST_HIT) ? hit_val_q : '0;
      out_ev_q     <= (status == ST_EVICT) ? vict_key_q : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_read_value_o  = out_rd_q;
  assign out_evicted_key_o = out_ev_q;

  assign sts_o.scan_last = cmd_i.scan && (cnt_q == UW'(ENTRIES));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // valid entries and fill count agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(used_q))
    else $error("fill count out of step with valid bits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed word not presented");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && grow) |-> !valid_q[sel])
    else $error("free insert landed on a valid entry");

endmodule

### hw/rtl/lru_key_value_cache_top.sv
// channel  | dir | handshake                   | word
// ---------+-----+-----------------------------+------------------------------------------
// request  | in  | s_axis_tvalid/s_axis_tready | tuser: opcode, tdata: key, value
// result   | out | m_axis_tvalid/m_axis_tready | tuser: status, tdata: read_value, evicted_key
// config   | in  | cfg_we_i                    | cfg_wdata_i: capacity
//
// a new request is taken only after the previous one commits: the key and value
// memories are swept one entry per cycle through their single read port, then the
// lookup commits
// reset clears valid bits, recency ranks and fill count at once; no clearing pass
// the result sits in its own register, so a new request is taken while it waits;
// a finished lookup commits only once that register is free
// capacity resets to 16; the user must write it only while the block is idle, unchecked by it
module lru_key_value_cache_top import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  // capacity register
  input  logic                                         cfg_we_i,
  input  logic [CapW-1:0]                              cfg_wdata_i,
  // request stream
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // tdata: key, value (low to high), zero padded to bytes
  input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // tuser: opcode
  input  logic                                         s_axis_tuser,
  // result stream
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // tdata: read_value, evicted_key (low to high), zero padded to bytes
  output logic [((VALUE_BITS+KEY_BITS+7)/8)*8-1:0]     m_axis_tdata,
  // tuser: status
  output logic [2:0]                                   m_axis_tuser
);

  localparam int unsigned OutW = ((VALUE_BITS + KEY_BITS + 7) / 8) * 8;

  dp_cmd_t cmd;
  dp_sts_t sts;

  logic [VALUE_BITS-1:0] read_value;
  logic [KEY_BITS-1:0]   evicted_key;

  // sequencing: accept, sweep, commit
  lkvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // entry store, recency lanes and result register
  lkvc_dp #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_opcode_i       (s_axis_tuser),
    .in_key_i          (s_axis_tdata[KEY_BITS-1:0]),
    .in_value_i        (s_axis_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS]),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_status_o      (m_axis_tuser),
    .out_read_value_o  (read_value),
    .out_evicted_key_o (evicted_key)
  );

  // pack result word, read value in the low bits
  assign m_axis_tdata = OutW'({evicted_key, read_value});

endmodule

### sim/lkvc_result_checker.sv
`timescale 1ns / 1ps
module lkvc_result_checker import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [CapW-1:0]                          cfg_wdata_i,
  input  logic                                     req_valid_i,
  input  logic                                     req_ready_i,
  // key, value (low to high)
  input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] req_data_i,
  // opcode
  input  logic                                     req_user_i,
  input  logic                                     rsp_valid_i,
  input  logic                                     rsp_ready_i,
  // read_value, evicted_key (low to high)
  input  logic [((VALUE_BITS+KEY_BITS+7)/8)*8-1:0] rsp_data_i,
  // status
  input  logic [2:0]                               rsp_user_i,
  output int unsigned                              fail_cnt_o,
  output int unsigned                              pending_o
);

  typedef struct {
    status_e                 status;
    logic [VALUE_BITS-1:0]   read_value;
    logic [KEY_BITS-1:0]     evicted_key;
  } cache_reply_t;

  logic [CapW-1:0]       capacity;
  logic                  slot_valid [ENTRIES];
  logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
  logic [VALUE_BITS-1:0] slot_value [ENTRIES];
  int unsigned           slot_age   [ENTRIES];
  int unsigned           fill;
  cache_reply_t          replies_due [$];

  // entries younger than limit age by one, slot s becomes the newest
  function automatic void make_newest(int s, int unsigned limit);
    for (int i = 0; i < ENTRIES; i++) begin
      if (i != s && slot_valid[i] && slot_age[i] < limit) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  function automatic cache_reply_t serve_request(logic op, logic [KEY_BITS-1:0] key,
                                                 logic [VALUE_BITS-1:0] val);
    cache_reply_t r;
    int           hit_slot;
    int           slot;
    int unsigned  limit;
    r.status      = ST_MISS;
    r.read_value  = '0;
    r.evicted_key = '0;
    hit_slot      = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_slot < 0 && slot_valid[i] && slot_key[i] == key) hit_slot = i;
    end
    // zero acts as one, anything above the entry count as the entry count
    limit = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : capacity);
    if (op == OpGet) begin
      if (hit_slot >= 0) begin
        r.status     = ST_HIT;
        r.read_value = slot_value[hit_slot];
        make_newest(hit_slot, slot_age[hit_slot]);
      end
    end else if (hit_slot >= 0) begin
      r.status = ST_DUP;
    end else begin
      if (fill < limit) begin
        slot = 0;
        while (slot < ENTRIES - 1 && slot_valid[slot]) slot++;
        r.status = ST_FREE;
        make_newest(slot, 32'hFFFF_FFFF);
        fill++;
      end else begin
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i] && (slot < 0 || slot_age[i] > slot_age[slot])) slot = i;
        end
        if (slot < 0) slot = 0;
        r.status      = ST_EVICT;
        r.evicted_key = slot_key[slot];
        make_newest(slot, slot_age[slot]);
      end
      slot_valid[slot] = 1'b1;
      slot_key[slot]   = key;
      slot_value[slot] = val;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cache_reply_t due;
    if (!rst_ni) begin
      capacity = CapReset;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_age[i]   = 0;
      end
      fill = 0;
      replies_due.delete();
      fail_cnt_o = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result word with none due, expected nothing, got status %0d data %h",
                   $time, rsp_user_i, rsp_data_i);
          fail_cnt_o++;
        end else begin
          due = replies_due.pop_front();
          if (rsp_user_i != due.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, due.status, rsp_user_i);
            fail_cnt_o++;
          end
          if (rsp_data_i[VALUE_BITS-1:0] != due.read_value) begin
            $display("%0t: read_value expected %h, actual %h", $time, due.read_value,
                     rsp_data_i[VALUE_BITS-1:0]);
            fail_cnt_o++;
          end
          if (rsp_data_i[VALUE_BITS +: KEY_BITS] != due.evicted_key) begin
            $display("%0t: evicted_key expected %h, actual %h", $time, due.evicted_key,
                     rsp_data_i[VALUE_BITS +: KEY_BITS]);
            fail_cnt_o++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        replies_due.push_back(serve_request(req_user_i, req_data_i[KEY_BITS-1:0],
                                            req_data_i[KEY_BITS +: VALUE_BITS]));
      end
      if (cfg_we_i) capacity = cfg_wdata_i;
    end
    pending_o = replies_due.size();
  end

endmodule

### sim/lru_key_value_cache_top_tb.sv
`timescale 1ns / 1ps
module lru_key_value_cache_top_tb;
  import lkvc_pkg::*;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned DataW      = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
  // each word sweeps all ENTRIES entries, plus random gaps on both sides
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned Phases     = 9;
  localparam int unsigned PhaseWords = 45;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CapW-1:0]  cfg_wdata_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata;
  logic             s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [DataW-1:0] m_axis_tdata;
  logic [2:0]       m_axis_tuser;

  int unsigned      fail_cnt;
  int unsigned      pending;
  // no idling on either side while set
  logic             calm;
  int unsigned      cycles;

  lru_key_value_cache_top #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // watches both streams and the config port, predicts and compares
  lkvc_result_checker #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (s_axis_tvalid),
    .req_ready_i (s_axis_tready),
    .req_data_i  (s_axis_tdata),
    .req_user_i  (s_axis_tuser),
    .rsp_valid_i (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .rsp_data_i  (m_axis_tdata),
    .rsp_user_i  (m_axis_tuser),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side: back-pressure in about a quarter of the cycles
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 24);
  end

  // hard stop in case the block hangs
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // present one request word and hold it until the block takes it
  task automatic send_req(logic op, logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] val);
    @(negedge clk_i);
    // random gaps before the word, skipped in the calm stretch
    while (!calm && $urandom_range(0, 99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {val, key};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // drop valid and wait until every expected result word has come back
  task automatic drain(int unsigned tail);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (tail) @(negedge clk_i);
  endtask

  // capacity is only written while the block is idle
  task automatic write_capacity(logic [CapW-1:0] cap);
    drain(4);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CapW-1:0]     cap_plan [Phases];
    logic [KEY_BITS-1:0] key_pool [20];
    int unsigned         pool_n;
    logic                op;
    logic [KEY_BITS-1:0] key;

    // capacity settings per random phase: reset value, small, zero, and above range
    cap_plan = '{5'd16, 5'd3, 5'd1, 5'd31, 5'd0, 5'd8, 5'd17, 5'd2, 5'd16};

    calm          = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = CapReset;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OpGet;
    m_axis_tready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty lookup, fills, duplicate, hits with junk value field
    send_req(OpGet, '0, '1);
    send_req(OpSet, '0, '0);
    send_req(OpSet, '1, '1);
    send_req(OpSet, '0, 32'h1234_5678);
    send_req(OpGet, '0, 32'hFFFF_FFFF);
    send_req(OpGet, '1, '0);
    send_req(OpSet, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_req(OpSet, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    send_req(OpGet, '0, '0);
    send_req(OpGet, 32'h8000_0001, '0);

    // capacity lowered below the four entries in use: new keys evict in place
    write_capacity(5'd2);
    send_req(OpSet, 32'd1, 32'd11);
    send_req(OpSet, 32'd2, 32'd22);
    send_req(OpGet, '1, '0);
    send_req(OpSet, 32'd1, '0);
    send_req(OpGet, 32'd1, '0);
    send_req(OpGet, 32'h5A5A_5A5A, '0);

    // zero capacity behaves as one
    write_capacity(5'd0);
    send_req(OpSet, 32'd3, 32'd33);
    send_req(OpSet, 32'd4, 32'd44);
    send_req(OpGet, 32'd3, '0);
    send_req(OpGet, 32'd4, '0);

    // random phases: a small key pool per phase so hits, duplicates and
    // evictions all show up, with an odd fully random key mixed in
    for (int p = 0; p < Phases; p++) begin
      write_capacity(cap_plan[p]);
      calm   = (p == 3);
      pool_n = $urandom_range(2, 20);
      for (int k = 0; k < 20; k++) key_pool[k] = $urandom;
      for (int n = 0; n < PhaseWords; n++) begin
        op  = $urandom_range(0, 1) ? OpSet : OpGet;
        key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
        send_req(op, key, $urandom);
      end
    end
    calm = 1'b0;

    // let the last results out and give stray words time to show
    drain(ENTRIES + 8);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
